/* hw/rtl/elrg_pkg.sv */
// ----------------------------------------------------------------------------
// elrg_pkg
// Shared widths, step counts and sideband types for the edge length kernel.
// ----------------------------------------------------------------------------
package elrg_pkg;

    localparam int COORD_W  = 32;             // Q16.16 coordinate
    localparam int DIFF_W   = 33;             // exact difference magnitude
    localparam int SQ_W     = 65;             // square of one difference
    localparam int RAD_W    = 66;             // sum of three squares
    localparam int ROOT_W   = 34;             // floor(sqrt) of the sum
    localparam int REST_W   = 31;
    localparam int QUO_W    = 31;             // gradient magnitude, Q1.30
    localparam int NUM_W    = 63;             // mag * 2^30 + len/2
    localparam int SQ_STEPS = ROOT_W;         // one root bit per stage
    localparam int DIV_STEPS = QUO_W;         // one quotient bit per stage
    localparam int FRAC_BITS = 16;            // format name only
    localparam logic [QUO_W-1:0] GRAD_ONE = QUO_W'(1) << 30;

    // travels alongside the root pipeline
    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][DIFF_W-1:0]  mag;
        logic [REST_W-1:0]       rest;
    } t_side;

    // travels alongside the divider pipeline
    typedef struct packed {
        logic [2:0]              neg;
        logic [REST_W-1:0]       rest;
    } t_tail;

endpackage

/* hw/rtl/edge_length_residual_gradient.sv */
// ----------------------------------------------------------------------------
// edge_length_residual_gradient
// Per-edge length error and unit direction (gradient) for mesh constraints.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  edge in  | start, busy          | i_first_xyz, i_second_xyz, i_rest_length
//  result   | o_valid (strobe)     | o_length_error, o_grad_xyz, o_degenerate
//
//  One edge per cycle, every cycle; busy is always low.
//  Pipeline: 3 front stages, 35 root stages, 1 setup stage, 32 divide stages
//  and 1 output stage; the root and divider resolve one bit per stage.
//  Reset (synchronous) clears only the valid chain; payload flops free-run.
//  The receiver cannot stall: each result strobes for exactly one cycle.
// ----------------------------------------------------------------------------
module edge_length_residual_gradient (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [elrg_pkg::COORD_W-1:0]    i_first_x,
    input  logic signed [elrg_pkg::COORD_W-1:0]    i_first_y,
    input  logic signed [elrg_pkg::COORD_W-1:0]    i_first_z,
    input  logic signed [elrg_pkg::COORD_W-1:0]    i_second_x,
    input  logic signed [elrg_pkg::COORD_W-1:0]    i_second_y,
    input  logic signed [elrg_pkg::COORD_W-1:0]    i_second_z,
    input  logic [elrg_pkg::REST_W-1:0]            i_rest_length,
    output logic                                   o_valid,
    output logic signed [31:0]                     o_length_error,
    output logic signed [31:0]                     o_grad_x,
    output logic signed [31:0]                     o_grad_y,
    output logic signed [31:0]                     o_grad_z,
    output logic                                   o_degenerate
);
    import elrg_pkg::*;

    // fully pipelined, never refuses an edge
    assign busy = 1'b0;

    // ---- stage 1: differences, split into sign and magnitude ---------------
    logic                        r_v1;
    logic [2:0]                  r_neg1;
    logic [2:0][DIFF_W-1:0]      r_mag1;
    logic [REST_W-1:0]           r_rest1;

    logic signed [DIFF_W:0]      n_diff [3];

    always_comb begin
        n_diff[0] = DIFF_W'(i_first_x) - DIFF_W'(i_second_x);
        n_diff[1] = DIFF_W'(i_first_y) - DIFF_W'(i_second_y);
        n_diff[2] = DIFF_W'(i_first_z) - DIFF_W'(i_second_z);
    end

    // ---- stage 2: squares --------------------------------------------------
    logic                        r_v2;
    logic [2:0][SQ_W-1:0]        r_sq2;
    t_side                       r_side2;

    // ---- stage 3: sum of squares -------------------------------------------
    logic                        r_v3;
    logic [RAD_W-1:0]            r_sum3;
    t_side                       r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_neg1[l] <= n_diff[l][DIFF_W];
            r_mag1[l] <= n_diff[l][DIFF_W] ? DIFF_W'(-n_diff[l]) : DIFF_W'(n_diff[l]);
            r_sq2[l]  <= SQ_W'(r_mag1[l] * r_mag1[l]);  // |d| <= 2^32
        end
        r_rest1       <= i_rest_length;
        r_side2.neg   <= r_neg1;
        r_side2.mag   <= r_mag1;
        r_side2.rest  <= r_rest1;
        r_sum3  <= RAD_W'(r_sq2[0]) + RAD_W'(r_sq2[1]) + RAD_W'(r_sq2[2]);
        r_side3 <= r_side2;
    end

    // ---- length: floor(sqrt(sum)) ------------------------------------------
    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    t_side                 sq_side;

    elrg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   (r_sum3),
        .i_side  (r_side3),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---- divide setup: numerator = |d| * 2^30 + len/2 (round half up) -------
    logic                     r_v4;
    logic [2:0][NUM_W-1:0]    r_num4;
    logic [ROOT_W-1:0]        r_len4;
    t_tail                    r_tail4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_num4[l] <= {sq_side.mag[l], 30'd0}
                         + NUM_W'(sq_root[ROOT_W-1:1]);
        end
        r_len4       <= sq_root;
        r_tail4.neg  <= sq_side.neg;
        r_tail4.rest <= sq_side.rest;
    end

    // ---- gradient magnitudes -----------------------------------------------
    logic                     dv_valid;
    logic [2:0][QUO_W-1:0]    dv_quo;
    logic [ROOT_W-1:0]        dv_len;
    t_tail                    dv_tail;

    elrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_num   (r_num4),
        .i_den   (r_len4),
        .i_tail  (r_tail4),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_den   (dv_len),
        .o_tail  (dv_tail)
    );

    // ---- output: sign, clamp, zero-length override, length error -----------
    logic                    n_degen;
    logic signed [ROOT_W+1:0] n_err;
    logic signed [31:0]      n_err_sat;
    logic [2:0][31:0]        n_grad;

    always_comb begin
        logic [QUO_W-1:0] mag;
        n_degen = (dv_len == '0);
        n_err   = $signed({2'b00, dv_len}) - $signed((ROOT_W+2)'(dv_tail.rest));
        if (n_err > $signed((ROOT_W+2)'(32'h7FFF_FFFF))) begin
            n_err_sat = 32'sh7FFF_FFFF;
        end else begin
            n_err_sat = n_err[31:0];   // never below -2^31: rest < 2^31
        end
        for (int l = 0; l < 3; l++) begin
            mag = (dv_quo[l] > GRAD_ONE) ? GRAD_ONE : dv_quo[l];
            if (n_degen) begin
                n_grad[l] = '0;
            end else if (dv_tail.neg[l]) begin
                n_grad[l] = -(32'(mag));
            end else begin
                n_grad[l] = 32'(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_length_error <= n_err_sat;
        o_grad_x       <= n_grad[0];
        o_grad_y       <= n_grad[1];
        o_grad_z       <= n_grad[2];
        o_degenerate   <= n_degen;
    end

    // ---- checks ------------------------------------------------------------
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_grad_x == 0 && o_grad_y == 0 && o_grad_z == 0)
        else $error("degenerate edge with nonzero gradient");

    a_grad_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_grad_x <= 32'sd1073741824 && o_grad_x >= -32'sd1073741824
                 && o_grad_y <= 32'sd1073741824 && o_grad_y >= -32'sd1073741824
                 && o_grad_z <= 32'sd1073741824 && o_grad_z >= -32'sd1073741824)
        else $error("gradient component above one");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

/* hw/rtl/elrg_sqrt.sv */
// ----------------------------------------------------------------------------
// elrg_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module elrg_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [elrg_pkg::RAD_W-1:0]   i_rad,
    input  elrg_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [elrg_pkg::ROOT_W-1:0]  o_root,
    output elrg_pkg::t_side              o_side
);
    import elrg_pkg::*;

    localparam int PAD_W = 2 * ROOT_W;   // radicand padded to whole bit pairs
    localparam int REM_W = ROOT_W + 3;

    logic                 r_v    [0:SQ_STEPS];
    logic [PAD_W-1:0]     r_rad  [0:SQ_STEPS];
    logic [REM_W-1:0]     r_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0]    r_root [0:SQ_STEPS];
    t_side                r_side [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= PAD_W'(i_rad);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] tsub;

        assign trial = {r_rem[k][REM_W-3:0], r_rad[k][PAD_W-1:PAD_W-2]};
        assign tsub  = {1'b0, r_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k+1]  <= {r_rad[k][PAD_W-3:0], 2'b00};
            r_side[k+1] <= r_side[k];
            if (trial >= tsub) begin
                r_rem[k+1]  <= trial - tsub;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= trial;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[SQ_STEPS];
    assign o_root  = r_root[SQ_STEPS];
    assign o_side  = r_side[SQ_STEPS];

endmodule

/* hw/rtl/elrg_div.sv */
// ----------------------------------------------------------------------------
// elrg_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module elrg_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [2:0][elrg_pkg::NUM_W-1:0]   i_num,
    input  logic [elrg_pkg::ROOT_W-1:0]       i_den,
    input  elrg_pkg::t_tail                   i_tail,
    output logic                              o_valid,
    output logic [2:0][elrg_pkg::QUO_W-1:0]   o_quo,
    output logic [elrg_pkg::ROOT_W-1:0]       o_den,
    output elrg_pkg::t_tail                   o_tail
);
    import elrg_pkg::*;

    localparam int REM_W = ROOT_W;
    localparam int HI_W  = NUM_W - QUO_W;

    logic                       r_v    [0:DIV_STEPS];
    logic [2:0][REM_W-1:0]      r_rem  [0:DIV_STEPS];
    logic [2:0][QUO_W-1:0]      r_low  [0:DIV_STEPS];
    logic [2:0][QUO_W-1:0]      r_quo  [0:DIV_STEPS];
    logic [ROOT_W-1:0]          r_den  [0:DIV_STEPS];
    t_tail                      r_tail [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    // high part of the numerator is below any nonzero divisor: quotient fits QUO_W
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l] <= REM_W'(i_num[l][NUM_W-1:QUO_W]);
            r_low[0][l] <= i_num[l][QUO_W-1:0];
        end
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_tail[0] <= i_tail;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic [2:0][REM_W-1:0] n_rem;
        logic [2:0]            n_bit;

        always_comb begin
            logic [REM_W:0] trial;
            for (int l = 0; l < 3; l++) begin
                trial = {r_rem[k][l], r_low[k][l][QUO_W-1]};
                if (trial >= {1'b0, r_den[k]}) begin
                    n_rem[l] = REM_W'(trial - {1'b0, r_den[k]});
                    n_bit[l] = 1'b1;
                end else begin
                    n_rem[l] = REM_W'(trial);
                    n_bit[l] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[k+1][l] <= n_rem[l];
                r_low[k+1][l] <= {r_low[k][l][QUO_W-2:0], 1'b0};
                r_quo[k+1][l] <= {r_quo[k][l][QUO_W-2:0], n_bit[l]};
            end
            r_den[k+1]  <= r_den[k];
            r_tail[k+1] <= r_tail[k];
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_quo   = r_quo[DIV_STEPS];
    assign o_den   = r_den[DIV_STEPS];
    assign o_tail  = r_tail[DIV_STEPS];

endmodule

/* tb/edge_length_residual_gradient_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_length_residual_gradient_chk
// Watches edge transfers and result strobes, predicts each result and
// compares it field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module edge_length_residual_gradient_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic [30:0]        i_rest_length,
    input  logic               o_valid,
    input  logic signed [31:0] o_length_error,
    input  logic signed [31:0] o_grad_x,
    input  logic signed [31:0] o_grad_y,
    input  logic signed [31:0] o_grad_z,
    input  logic               o_degenerate,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [31:0] length_error;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
        logic [31:0] grad_z;
        logic        degenerate;
    } t_edge_result;

    t_edge_result expected_results[$];
    int           error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // bit-serial floor(sqrt) of the 66-bit sum of squares
    function automatic logic [33:0] root_floor(input logic [65:0] radicand);
        logic [33:0] root;
        logic [33:0] trial;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if (68'(trial) * 68'(trial) <= 68'(radicand))
                root = trial;
        end
        return root;
    endfunction

    // |d| / len in Q1.30, rounded half away, clamped at one, sign applied
    function automatic logic [31:0] unit_component(input logic signed [32:0] d,
                                                   input logic [33:0] len);
        logic [32:0] mag;
        logic [64:0] quo;
        if (len == 0)
            return '0;
        mag = d < 0 ? 33'(-d) : 33'(d);
        quo = ((65'(mag) << 30) + 65'(len >> 1)) / 65'(len);
        if (quo > (65'd1 << 30))
            quo = 65'd1 << 30;
        return d < 0 ? 32'(-quo) : 32'(quo);
    endfunction

    function automatic t_edge_result predict_edge(
        input logic signed [31:0] fx, fy, fz, sx, sy, sz,
        input logic [30:0] rest);
        t_edge_result r;
        logic signed [32:0] dx, dy, dz;
        logic [65:0] sum;
        logic [33:0] len;
        logic signed [35:0] err;
        dx = 33'(fx) - 33'(sx);
        dy = 33'(fy) - 33'(sy);
        dz = 33'(fz) - 33'(sz);
        sum = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
        len = root_floor(sum);
        err = $signed({2'b0, len}) - $signed({5'b0, rest});
        if (err > 36'sh7FFFFFFF)
            err = 36'sh7FFFFFFF;
        if (err < -36'sh80000000)
            err = -36'sh80000000;
        r.length_error = err[31:0];
        r.grad_x = unit_component(dx, len);
        r.grad_y = unit_component(dy, len);
        r.grad_z = unit_component(dz, len);
        r.degenerate = len == 0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result transfer", $realtime);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_length_error !== want.length_error)
                    report_mismatch("length_error", o_length_error, want.length_error);
                if (o_grad_x !== want.grad_x)
                    report_mismatch("grad_x", o_grad_x, want.grad_x);
                if (o_grad_y !== want.grad_y)
                    report_mismatch("grad_y", o_grad_y, want.grad_y);
                if (o_grad_z !== want.grad_z)
                    report_mismatch("grad_z", o_grad_z, want.grad_z);
                if (o_degenerate !== want.degenerate)
                    report_mismatch("degenerate", 32'(o_degenerate), 32'(want.degenerate));
            end
        end
        if (i_rst_n && start && !busy)
            expected_results.push_back(predict_edge(i_first_x, i_first_y, i_first_z,
                i_second_x, i_second_y, i_second_z, i_rest_length));
    end

endmodule

/* tb/edge_length_residual_gradient_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_length_residual_gradient_tb
// Drives directed and random edges in bursts; a checker beside the block
// predicts every result and the top reports the verdict.
// ----------------------------------------------------------------------------
module edge_length_residual_gradient_tb;

    localparam int N_RANDOM     = 850;
    localparam int LATENCY      = 72;
    localparam int WATCHDOG_MAX = 2000;   // idle cycles with no transfer

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic [30:0]        i_rest_length = '0;
    logic               o_valid, o_degenerate;
    logic signed [31:0] o_length_error, o_grad_x, o_grad_y, o_grad_z;
    int                 error_count, pending_count;
    int                 idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    edge_length_residual_gradient dut (.*);

    edge_length_residual_gradient_chk checker_i (
        .*, .o_errors(error_count), .o_pending(pending_count));

    // watchdog: any transfer on either side resets the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("edge_length_residual_gradient_tb: done, errors");
            $finish;
        end
    end

    // small random coordinate: exercises short edges and near-coincident vertices
    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 64)) - 32);
    endfunction

    // present one edge and hold it until the transfer
    task automatic send_edge(input logic [31:0] fx, fy, fz, sx, sy, sz,
                             input logic [30:0] rest);
        i_first_x     <= fx;
        i_first_y     <= fy;
        i_first_z     <= fz;
        i_second_x    <= sx;
        i_second_y    <= sy;
        i_second_z    <= sz;
        i_rest_length <= rest;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_random_edge();
        logic [31:0] v[6];
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 6; k++)
            case (mode)
                0, 1, 2: v[k] = $urandom();
                3, 4:    v[k] = 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'h40000);
                5:       v[k] = near_coord();
                default: v[k] = 32'($signed($urandom_range(0, 32'hFFFFFF)) - 32'h800000);
            endcase
        if (mode == 5 && $urandom_range(0, 3) == 0) begin
            // coinciding vertices
            v[3] = v[0];
            v[4] = v[1];
            v[5] = v[2];
        end
        send_edge(v[0], v[1], v[2], v[3], v[4], v[5],
                  $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'hFFFFFF)));
    endtask

    localparam logic [31:0] MAXP = 32'h7FFFFFFF;
    localparam logic [31:0] MAXN = 32'h80000000;

    initial begin
        int gap;
        int burst;
        int sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, axis edges, coinciding vertices, saturation
        send_edge(0, 0, 0, 0, 0, 0, 0);
        send_edge(5, 5, 5, 5, 5, 5, 31'h7FFFFFFF);            // degenerate, max rest
        send_edge(MAXP, MAXP, MAXP, MAXN, MAXN, MAXN, 0);      // longest edge, error clamps
        send_edge(MAXN, MAXN, MAXN, MAXP, MAXP, MAXP, 31'h7FFFFFFF);
        send_edge(MAXN, 0, 0, MAXP, 0, 0, 1);
        send_edge(0, MAXP, 0, 0, MAXN, 0, 0);
        send_edge(0, 0, MAXN, 0, 0, MAXP, 0);
        send_edge(32'h10000, 0, 0, 0, 0, 0, 31'h10000);        // unit length, zero error
        send_edge(0, 32'hFFFF0000, 0, 0, 0, 0, 31'h20000);
        send_edge(1, 1, 1, 0, 0, 0, 0);                         // truncated root, grad components at one
        send_edge(0, 0, 0, 1, 1, 0, 3);
        send_edge(2, 1, 0, 0, 0, 0, 0);
        send_edge(3, 4, 0, 0, 0, 0, 31'h7FFFFFFF);              // error near lower clamp
        send_edge(MAXP, MAXN, MAXP, 0, 0, 0, 0);
        send_edge(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_edge(0, 0, 0, MAXP, 0, MAXN, 31'h55555555);
        start <= 1'b0;

        // random bursts with random gaps
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                send_random_edge();
                sent++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (pending_count != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("edge_length_residual_gradient_tb: done, clean");
        else
            $display("edge_length_residual_gradient_tb: done, errors");
        $finish;
    end

endmodule
